// ===== rtl/core/min_tracking_stack_unit_macros.svh =====
// Assertion macros shared by the checker of the min tracking stack.
// Needs clk_i and rst_ni in the scope where a macro is used.
`ifndef MIN_TRACKING_STACK_UNIT_MACROS_SVH
`define MIN_TRACKING_STACK_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is applied.
`define MTS_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is applied.
`define MTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/mts_pkg.sv =====
// Package of the min tracking stack: field widths, codes and the
// command and result records. Depends on nothing.
package mts_pkg;

  localparam int WORD_W        = 32;
  localparam int COUNT_OUT_W   = 7;
  localparam int DEPTH_DEFAULT = 64;
  localparam int VALUE_W_DEFAULT = 32;

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_UNDERFLOW = 2'd1,
    STATUS_OVERFLOW  = 2'd2
  } status_e;

  typedef struct packed {
    func_e             func;
    logic [WORD_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic [WORD_W-1:0]      popped_value;
    logic [WORD_W-1:0]      min_value;
    logic                   stack_empty;
    status_e                status;
    logic [COUNT_OUT_W-1:0] entry_count;
  } rsp_t;

endpackage

// ===== rtl/core/mts_req_if.sv =====
// Request channel of the min tracking stack: valid/ready and the command.
// Depends on nothing.
interface mts_req_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [31:0] push_value;

  modport source (output valid, output func, output push_value, input ready);
  modport sink (input valid, input func, input push_value, output ready);
endinterface

// ===== rtl/core/mts_rsp_if.sv =====
// Result channel of the min tracking stack: valid/ready and the result.
// Depends on nothing.
interface mts_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] popped_value;
  logic [31:0] min_value;
  logic        stack_empty;
  logic [1:0]  status;
  logic [6:0]  entry_count;

  modport source (output valid, output popped_value, output min_value,
                  output stack_empty, output status, output entry_count, input ready);
  modport sink (input valid, input popped_value, input min_value,
                input stack_empty, input status, input entry_count, output ready);
endinterface

// ===== rtl/core/mts_stack_ram.sv =====
// Single write port, single read port memory with a registered read.
// Depends on nothing.
module mts_stack_ram #(
  parameter int Depth = 64,
  parameter int Width = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mts_ctrl.sv =====
// Stack controller: counts, cached tops and the read-modify-write sequence
// over the value and minimum memories. Depends on mts_pkg.
module mts_ctrl #(
  parameter int StackDepth = mts_pkg::DEPTH_DEFAULT,
  parameter int ValueWidth = mts_pkg::VALUE_W_DEFAULT
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  mts_pkg::cmd_t                 cmd_i,
  output logic                          idle_o,
  output logic                          res_valid_o,
  output mts_pkg::rsp_t                 res_o,
  // value memory
  output logic                          v_we_o,
  output logic [$clog2(StackDepth)-1:0] v_waddr_o,
  output logic [ValueWidth-1:0]         v_wdata_o,
  output logic                          v_re_o,
  output logic [$clog2(StackDepth)-1:0] v_raddr_o,
  input  logic [ValueWidth-1:0]         v_rdata_i,
  // minimum memory
  output logic                          m_we_o,
  output logic [$clog2(StackDepth)-1:0] m_waddr_o,
  output logic [ValueWidth-1:0]         m_wdata_o,
  output logic                          m_re_o,
  output logic [$clog2(StackDepth)-1:0] m_raddr_o,
  input  logic [ValueWidth-1:0]         m_rdata_i
);

  localparam int AW    = $clog2(StackDepth);
  localparam int CW    = $clog2(StackDepth + 1);
  localparam int WordW = mts_pkg::WORD_W;
  localparam int CntW  = mts_pkg::COUNT_OUT_W;

  typedef enum logic {
    S_IDLE,
    S_FILL
  } state_e;

  state_e                state_q, state_d;
  logic [CW-1:0]         vcnt_q, vcnt_d;
  logic [CW-1:0]         mcnt_q, mcnt_d;
  logic [ValueWidth-1:0] vtop_q, vtop_d;
  logic [ValueWidth-1:0] mtop_q, mtop_d;
  logic [ValueWidth-1:0] popped_q, popped_d;
  logic                  mpop_q, mpop_d;

  logic [ValueWidth-1:0] v_in;
  logic [CW-1:0]         mcnt_eff;
  logic [CW-1:0]         v_rd_ptr;
  logic [CW-1:0]         m_rd_ptr;
  logic                  min_push;
  logic                  min_hit;
  logic [ValueWidth-1:0] new_min;

  assign v_in     = ValueWidth'($signed(cmd_i.push_value));
  // An empty value stack implies an empty minimum stack.
  assign mcnt_eff = (vcnt_q == '0) ? '0 : mcnt_q;
  assign v_rd_ptr = vcnt_q - CW'(2);
  assign m_rd_ptr = mcnt_q - CW'(2);
  assign min_push = (mcnt_eff == '0) || ($signed(v_in) <= $signed(mtop_q));
  assign min_hit  = (mcnt_q != '0) && (mtop_q == vtop_q);
  assign new_min  = mpop_q ? m_rdata_i : mtop_q;

  assign v_waddr_o = vcnt_q[AW-1:0];
  assign v_wdata_o = v_in;
  assign v_raddr_o = v_rd_ptr[AW-1:0];
  assign m_waddr_o = mcnt_eff[AW-1:0];
  assign m_wdata_o = v_in;
  assign m_raddr_o = m_rd_ptr[AW-1:0];
  assign idle_o    = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    vcnt_d      = vcnt_q;
    mcnt_d      = mcnt_q;
    vtop_d      = vtop_q;
    mtop_d      = mtop_q;
    popped_d    = popped_q;
    mpop_d      = mpop_q;
    v_we_o      = 1'b0;
    m_we_o      = 1'b0;
    v_re_o      = 1'b0;
    m_re_o      = 1'b0;
    res_valid_o = 1'b0;
    res_o              = '0;
    res_o.status       = mts_pkg::STATUS_OK;
    res_o.entry_count  = CntW'(vcnt_q);
    res_o.stack_empty  = (vcnt_q == '0);

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_valid_o = 1'b1;
          if (cmd_i.func == mts_pkg::FUNC_PUSH) begin
            if (vcnt_q == CW'(StackDepth)) begin
              // Full: drop the value, report the current minimum.
              res_o.status    = mts_pkg::STATUS_OVERFLOW;
              res_o.min_value = (mcnt_eff != '0) ? WordW'(mtop_q) : '0;
            end else begin
              v_we_o = 1'b1;
              vtop_d = v_in;
              vcnt_d = vcnt_q + CW'(1);
              mcnt_d = mcnt_eff;
              if (min_push && (mcnt_eff < CW'(StackDepth))) begin
                m_we_o = 1'b1;
                mtop_d = v_in;
                mcnt_d = mcnt_eff + CW'(1);
              end
              res_o.min_value   = min_push ? WordW'(v_in) : WordW'(mtop_q);
              res_o.entry_count = CntW'(vcnt_q + CW'(1));
              res_o.stack_empty = 1'b0;
            end
          end else begin
            if (vcnt_q == '0) begin
              res_o.status = mts_pkg::STATUS_UNDERFLOW;
            end else begin
              // Fetch below value top, and min top if popped; result waits.
              res_valid_o = 1'b0;
              popped_d    = vtop_q;
              mpop_d      = min_hit;
              vcnt_d      = vcnt_q - CW'(1);
              v_re_o      = 1'b1;
              if (min_hit) begin
                mcnt_d = mcnt_q - CW'(1);
                m_re_o = 1'b1;
              end
              state_d = S_FILL;
            end
          end
        end
      end
      S_FILL: begin
        vtop_d = v_rdata_i;
        mtop_d = new_min;
        res_valid_o        = 1'b1;
        res_o.popped_value = WordW'(popped_q);
        res_o.min_value    = ((vcnt_q == '0) || (mcnt_q == '0)) ? '0 : WordW'(new_min);
        state_d            = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      vcnt_q  <= '0;
      mcnt_q  <= '0;
      mpop_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      vcnt_q  <= vcnt_d;
      mcnt_q  <= mcnt_d;
      mpop_q  <= mpop_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vtop_q   <= vtop_d;
    mtop_q   <= mtop_d;
    popped_q <= popped_d;
  end

endmodule

// ===== rtl/core/min_tracking_stack_unit.sv =====
// Min tracking stack: a LIFO of signed words that reports its minimum after
// every operation. Depends on mts_pkg, mts_req_if, mts_rsp_if, mts_ctrl and
// mts_stack_ram.
//
// Usage:
//  - req_i carries one command per transfer: func (0 push, 1 pop) and
//    push_value. rsp_o carries exactly one result per command, in order:
//    popped value, minimum after the operation, empty flag, status and
//    entry count.
//  - A push, an overflowing push and an underflowing pop give their
//    result in the cycle after the transfer. A pop that removes an entry
//    reads the entry below the value top, and below the minimum top if
//    that is popped too, then loads its result into the output register.
//  - Throughput: one push per cycle while results are taken; a pop holds
//    the request channel until its value and any minimum read return.
//  - Reset empties both stacks at once through their counts; memory
//    contents are left as they are and no clearing pass runs.
//  - When the receiver stalls the result stays in the output register and
//    req_i.ready drops until the register is taken.
module min_tracking_stack_unit #(
  parameter int StackDepth = mts_pkg::DEPTH_DEFAULT,
  parameter int ValueWidth = mts_pkg::VALUE_W_DEFAULT
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  mts_req_if.sink       req_i,
  mts_rsp_if.source     rsp_o
);

  localparam int AW = $clog2(StackDepth);

  mts_pkg::cmd_t         cmd;
  mts_pkg::rsp_t         res;
  mts_pkg::rsp_t         out_q;
  logic                  out_valid_q;
  logic                  ctrl_idle;
  logic                  res_valid;
  logic                  accept;

  logic                  v_we, v_re, m_we, m_re;
  logic [AW-1:0]         v_waddr, v_raddr, m_waddr, m_raddr;
  logic [ValueWidth-1:0] v_wdata, v_rdata, m_wdata, m_rdata;

  // Take a command only when the controller is idle and the output
  // register is free or being drained in this cycle.
  assign req_i.ready = ctrl_idle && (!out_valid_q || rsp_o.ready);
  assign accept      = req_i.valid && req_i.ready;

  assign cmd.func       = mts_pkg::func_e'(req_i.func);
  assign cmd.push_value = req_i.push_value;

  mts_ctrl #(
    .StackDepth (StackDepth),
    .ValueWidth (ValueWidth)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .cmd_i       (cmd),
    .idle_o      (ctrl_idle),
    .res_valid_o (res_valid),
    .res_o       (res),
    .v_we_o      (v_we),
    .v_waddr_o   (v_waddr),
    .v_wdata_o   (v_wdata),
    .v_re_o      (v_re),
    .v_raddr_o   (v_raddr),
    .v_rdata_i   (v_rdata),
    .m_we_o      (m_we),
    .m_waddr_o   (m_waddr),
    .m_wdata_o   (m_wdata),
    .m_re_o      (m_re),
    .m_raddr_o   (m_raddr),
    .m_rdata_i   (m_rdata)
  );

  // Value stack entries below and including the top.
  mts_stack_ram #(
    .Depth (StackDepth),
    .Width (ValueWidth)
  ) u_value_ram (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .waddr_i (v_waddr),
    .wdata_i (v_wdata),
    .re_i    (v_re),
    .raddr_i (v_raddr),
    .rdata_o (v_rdata)
  );

  // Minimum stack: running minima, duplicates kept for ties.
  mts_stack_ram #(
    .Depth (StackDepth),
    .Width (ValueWidth)
  ) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (m_re),
    .raddr_i (m_raddr),
    .rdata_o (m_rdata)
  );

  // Output register: load a fresh result, drop it once transferred.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.popped_value = out_q.popped_value;
  assign rsp_o.min_value    = out_q.min_value;
  assign rsp_o.stack_empty  = out_q.stack_empty;
  assign rsp_o.status       = out_q.status;
  assign rsp_o.entry_count  = out_q.entry_count;

endmodule

// ===== rtl/core/mts_checker.sv =====
// Port-level checks of the min tracking stack, bound to the top level.
// Depends on mts_pkg and min_tracking_stack_unit_macros.svh.
`include "min_tracking_stack_unit_macros.svh"

module mts_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] popped_value_i,
  input logic [31:0] min_value_i,
  input logic        stack_empty_i,
  input logic [1:0]  status_i,
  input logic [6:0]  entry_count_i
);

  `MTS_ASSERT_NEXT(a_rsp_hold, rsp_valid_i && !rsp_ready_i, rsp_valid_i, "result dropped while stalled")

  `MTS_ASSERT_NOW(a_empty_count, rsp_valid_i && stack_empty_i, entry_count_i == '0, "empty with entries")

  `MTS_ASSERT_NOW(a_empty_min, rsp_valid_i && stack_empty_i, min_value_i == '0, "empty with a minimum")

  `MTS_ASSERT_NOW(a_underflow, rsp_valid_i && (status_i == mts_pkg::STATUS_UNDERFLOW), stack_empty_i && (popped_value_i == '0), "underflow result not empty")

endmodule

bind min_tracking_stack_unit mts_checker u_mts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .rsp_valid_i    (rsp_o.valid),
  .rsp_ready_i    (rsp_o.ready),
  .popped_value_i (rsp_o.popped_value),
  .min_value_i    (rsp_o.min_value),
  .stack_empty_i  (rsp_o.stack_empty),
  .status_i       (rsp_o.status),
  .entry_count_i  (rsp_o.entry_count)
);
